FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/mcrb_pkg.sv
`default_nettype none

package mcrb_pkg;

   localparam int CMD_W  = 2;
   localparam int CHAN_W = 3;
   localparam int BYTE_W = 8;
   localparam int FILL_W = 9;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_FLUSH = 2'd2,
      CMD_QUERY = 2'd3
   } cmd_type;

endpackage

`default_nettype wire

FILE: rtl/mcrb_if.sv
`default_nettype none

interface mcrb_req_if import mcrb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [CHAN_W-1:0] chan;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, cmd, chan, rx_byte, input ready);
   modport sink   (input valid, cmd, chan, rx_byte, output ready);
endinterface

interface mcrb_rsp_if import mcrb_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic [FILL_W-1:0] fill_count;
   logic              was_empty;
   logic              overwrote;

   modport source (output valid, out_byte, fill_count, was_empty, overwrote, input ready);
   modport sink   (input valid, out_byte, fill_count, was_empty, overwrote, output ready);
endinterface

`default_nettype wire

FILE: rtl/multichannel_rx_ring_buffer_top.sv
// Channel  Dir  Payload                                      Handshake
// req_ch   in   cmd, chan, rx_byte                           valid/ready
// rsp_ch   out  out_byte, fill_count, was_empty, overwrote   valid/ready
//
// One item per cycle unless a result stalls; each gives one result item in
// the cycle after it is taken, out of the byte store's registered read port.
// Per-channel positions and counts live in flops and are updated at the
// accept edge, so the next item on the same channel sees them directly.
// Reset is synchronous; positions and counts clear in the reset cycle,
// the byte store is not cleared.
// A stalled result holds its slot; a new item is taken in the same cycle
// the waiting result leaves.
`default_nettype none

module multichannel_rx_ring_buffer_top import mcrb_pkg::*; #(
   parameter int NUM_CHANNELS = 6,
   parameter int BUF_DEPTH    = 256
) (
   input  wire logic   clock,
   input  wire logic   reset,
   mcrb_req_if.sink    req_ch,
   mcrb_rsp_if.source  rsp_ch
);

   localparam int CH_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CX_W      = CH_W + CHAN_W;
   localparam int PW        = $clog2(BUF_DEPTH);
   localparam int CW        = $clog2(BUF_DEPTH + 1);
   localparam int FX_W      = (CW > FILL_W) ? CW : FILL_W;
   localparam int ADDR_W    = CH_W + PW;
   localparam int MEM_DEPTH = NUM_CHANNELS * (1 << PW);

   // per-channel state
   logic [PW-1:0] wpos_ff [NUM_CHANNELS];
   logic [PW-1:0] rpos_ff [NUM_CHANNELS];
   logic [CW-1:0] cnt_ff  [NUM_CHANNELS];

   // byte store
   logic [BYTE_W-1:0] mem [MEM_DEPTH];
   logic [BYTE_W-1:0] mem_rd_ff;

   // result stage
   logic              rsp_valid_ff;
   logic              pop_ok_ff;
   logic [FILL_W-1:0] fill_ff;
   logic              empty_ff;
   logic              ovw_ff;

   logic              accept;
   logic [CX_W-1:0]   chan_x;
   logic [CH_W-1:0]   ch_idx;
   logic              in_range;
   cmd_type           cmd;
   logic [PW-1:0]     cur_w;
   logic [PW-1:0]     cur_r;
   logic [CW-1:0]     cur_c;
   logic [PW-1:0]     next_w;
   logic [PW-1:0]     next_r;
   logic [PW-1:0]     wpos_in;
   logic [PW-1:0]     rpos_in;
   logic [CW-1:0]     cnt_in;
   logic [CW-1:0]     cnt_out;
   logic [FX_W-1:0]   fill_x;
   logic              pop_ok;
   logic              empty;
   logic              ovw;
   logic              mem_we;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_addr;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   assign chan_x   = CX_W'(req_ch.chan);
   assign ch_idx   = chan_x[CH_W-1:0];
   assign in_range = chan_x < CX_W'(NUM_CHANNELS);
   assign cmd      = cmd_type'(req_ch.cmd);

   assign cur_w  = wpos_ff[ch_idx];
   assign cur_r  = rpos_ff[ch_idx];
   assign cur_c  = cnt_ff[ch_idx];
   assign next_w = (cur_w == PW'(BUF_DEPTH - 1)) ? '0 : cur_w + 1'b1;
   assign next_r = (cur_r == PW'(BUF_DEPTH - 1)) ? '0 : cur_r + 1'b1;

   always_comb begin
      wpos_in = cur_w;
      rpos_in = cur_r;
      cnt_in  = cur_c;
      pop_ok  = 1'b0;
      empty   = 1'b0;
      ovw     = 1'b0;
      unique case (cmd)
         CMD_PUSH: begin
            wpos_in = next_w;
            if (cur_c < CW'(BUF_DEPTH)) begin
               cnt_in = cur_c + 1'b1;
            end else begin
               rpos_in = next_w;
               ovw     = 1'b1;
            end
         end
         CMD_POP: begin
            if (cur_c == '0) begin
               empty = 1'b1;
            end else begin
               pop_ok = 1'b1;
               cnt_in = cur_c - 1'b1;
               // last byte gone: read position snaps to the write position
               rpos_in = (cur_c == CW'(1)) ? cur_w : next_r;
            end
         end
         CMD_FLUSH: begin
            wpos_in = '0;
            rpos_in = '0;
            cnt_in  = '0;
         end
         CMD_QUERY: begin
         end
         default: begin
         end
      endcase
   end

   assign cnt_out  = in_range ? cnt_in : '0;
   assign fill_x   = FX_W'(cnt_out);
   assign mem_we   = accept && in_range && (cmd == CMD_PUSH);
   assign mem_re   = accept && in_range && pop_ok;
   assign mem_addr = {ch_idx, (cmd == CMD_PUSH) ? cur_w : cur_r};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            wpos_ff[i] <= '0;
            rpos_ff[i] <= '0;
            cnt_ff[i]  <= '0;
         end
      end else if (accept && in_range) begin
         wpos_ff[ch_idx] <= wpos_in;
         rpos_ff[ch_idx] <= rpos_in;
         cnt_ff[ch_idx]  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= req_ch.rx_byte;
      end
      if (mem_re) begin
         mem_rd_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pop_ok_ff <= pop_ok && in_range;
         fill_ff   <= fill_x[FILL_W-1:0];
         empty_ff  <= empty && in_range;
         ovw_ff    <= ovw && in_range;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_byte   = pop_ok_ff ? mem_rd_ff : '0;
   assign rsp_ch.fill_count = fill_ff;
   assign rsp_ch.was_empty  = empty_ff;
   assign rsp_ch.overwrote  = ovw_ff;

endmodule

`default_nettype wire

FILE: rtl/mcrb_checker.sv
`default_nettype none

`include "assert_macros.svh"

module mcrb_checker import mcrb_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [BYTE_W-1:0] out_byte,
   input wire logic [FILL_W-1:0] fill_count,
   input wire logic              was_empty,
   input wire logic              overwrote
);

   `ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_item_gives_rsp, clock, reset, req_valid && req_ready, rsp_valid)
   `ASSERT_IMPL(a_rsp_has_item, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready))
   `ASSERT_IMPL(a_empty_pop_zero, clock, reset, rsp_valid && was_empty, out_byte == '0 && fill_count == '0 && !overwrote)

endmodule

bind multichannel_rx_ring_buffer_top mcrb_checker u_mcrb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .out_byte   (rsp_ch.out_byte),
   .fill_count (rsp_ch.fill_count),
   .was_empty  (rsp_ch.was_empty),
   .overwrote  (rsp_ch.overwrote)
);

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;
   import mcrb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CH      = 6;
   localparam int DEPTH       = 256;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [FILL_W-1:0] fill_count;
      logic              was_empty;
      logic              overwrote;
   } ring_result_type;

   logic clock;
   logic reset;

   mcrb_req_if req_ch ();
   mcrb_rsp_if rsp_ch ();

   multichannel_rx_ring_buffer_top #(
      .NUM_CHANNELS (NUM_CH),
      .BUF_DEPTH    (DEPTH)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // shadow copy of the per-channel rings
   logic [BYTE_W-1:0] ring_bytes [NUM_CH][DEPTH];
   int unsigned       ring_wr    [NUM_CH];
   int unsigned       ring_rd    [NUM_CH];
   int unsigned       ring_fill  [NUM_CH];

   ring_result_type pending_results [$];

   int src_idle_pct;
   int snk_stall_pct;
   int hold_len;
   int hold_left;
   int fail_count;
   int cycle_count;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, pending_results.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_len > 0) begin
         hold_left = hold_len;
         hold_len  = 0;
      end
      if (hold_left > 0) begin
         rsp_ch.ready = 1'b0;
         hold_left--;
      end else begin
         rsp_ch.ready = ($urandom_range(99) >= snk_stall_pct);
      end
   end

   function automatic ring_result_type apply_ring_op(cmd_type op, logic [CHAN_W-1:0] ch,
                                                     logic [BYTE_W-1:0] data);
      ring_result_type r;
      r = '0;
      if (ch < NUM_CH) begin
         case (op)
            CMD_PUSH: begin
               ring_bytes[ch][ring_wr[ch]] = data;
               ring_wr[ch] = (ring_wr[ch] + 1) % DEPTH;
               if (ring_fill[ch] < DEPTH) begin
                  ring_fill[ch]++;
               end else begin
                  // full: oldest byte lost, read side follows write side
                  ring_rd[ch] = ring_wr[ch];
                  r.overwrote = 1'b1;
               end
            end
            CMD_POP: begin
               if (ring_fill[ch] == 0) begin
                  r.was_empty = 1'b1;
               end else begin
                  r.out_byte = ring_bytes[ch][ring_rd[ch]];
                  ring_rd[ch] = (ring_rd[ch] + 1) % DEPTH;
                  ring_fill[ch]--;
                  if (ring_fill[ch] == 0) ring_rd[ch] = ring_wr[ch];
               end
            end
            CMD_FLUSH: begin
               ring_fill[ch] = 0;
               ring_wr[ch]   = 0;
               ring_rd[ch]   = 0;
            end
            default: ;
         endcase
         r.fill_count = FILL_W'(ring_fill[ch]);
      end
      return r;
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin : check_results
      ring_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected result byte=%0h fill=%0d empty=%b ovw=%b",
                                   rsp_ch.out_byte, rsp_ch.fill_count,
                                   rsp_ch.was_empty, rsp_ch.overwrote));
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.out_byte !== want.out_byte || rsp_ch.fill_count !== want.fill_count ||
                rsp_ch.was_empty !== want.was_empty || rsp_ch.overwrote !== want.overwrote) begin
               note_failure($sformatf(
                  "exp byte=%0h fill=%0d empty=%b ovw=%b, got byte=%0h fill=%0d empty=%b ovw=%b",
                  want.out_byte, want.fill_count, want.was_empty, want.overwrote,
                  rsp_ch.out_byte, rsp_ch.fill_count, rsp_ch.was_empty, rsp_ch.overwrote));
            end
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_item(cmd_type op, logic [CHAN_W-1:0] ch, logic [BYTE_W-1:0] data);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.cmd     = op;
      req_ch.chan    = ch;
      req_ch.rx_byte = data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_results.push_back(apply_ring_op(op, ch, data));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic test_basic_ops();
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      send_item(CMD_POP,   3'd0, 8'h5A);   // pop on empty channel
      send_item(CMD_QUERY, 3'd0, 8'h00);
      send_item(CMD_PUSH,  3'd0, 8'h00);
      send_item(CMD_PUSH,  3'd0, 8'hFF);
      send_item(CMD_QUERY, 3'd0, 8'hFF);
      send_item(CMD_POP,   3'd0, 8'h00);
      send_item(CMD_POP,   3'd0, 8'h00);   // empties, read side snaps to write side
      send_item(CMD_POP,   3'd0, 8'h00);
      send_item(CMD_PUSH,  3'd0, 8'h3C);
      send_item(CMD_POP,   3'd0, 8'h00);
      send_item(CMD_PUSH,  3'd5, 8'hA5);
      send_item(CMD_PUSH,  3'd5, 8'h5A);
      send_item(CMD_FLUSH, 3'd5, 8'h00);
      send_item(CMD_POP,   3'd5, 8'h00);
      send_item(CMD_PUSH,  3'd5, 8'h81);
      send_item(CMD_POP,   3'd5, 8'h00);
      // out-of-range channels do nothing
      send_item(CMD_PUSH,  3'd6, 8'hFF);
      send_item(CMD_PUSH,  3'd7, 8'hFF);
      send_item(CMD_POP,   3'd7, 8'h00);
      send_item(CMD_FLUSH, 3'd7, 8'h00);
      send_item(CMD_QUERY, 3'd6, 8'h00);
      for (int c = 0; c < NUM_CH; c++) send_item(CMD_PUSH, CHAN_W'(c), BYTE_W'(8'h10 + c));
      wait_drained();
   endtask

   task automatic test_full_overwrite();
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      for (int i = 0; i < DEPTH + 5; i++) send_item(CMD_PUSH, 3'd3, BYTE_W'($urandom));
      send_item(CMD_QUERY, 3'd3, 8'h00);
      // drain through the wrap point and one past empty
      for (int i = 0; i < DEPTH + 1; i++) send_item(CMD_POP, 3'd3, 8'h00);
      send_item(CMD_PUSH,  3'd3, 8'hC3);
      send_item(CMD_FLUSH, 3'd3, 8'h00);
      send_item(CMD_POP,   3'd3, 8'h00);
      wait_drained();
   endtask

   task automatic test_backpressure();
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      hold_len = 60;
      for (int i = 0; i < 16; i++) begin
         if (i % 3 == 2) send_item(CMD_POP, 3'd2, 8'h00);
         else send_item(CMD_PUSH, 3'd2, BYTE_W'($urandom));
      end
      wait_drained();
      for (int i = 0; i < 10; i++) send_item(CMD_POP, 3'd2, 8'h00);
      wait_drained();
   endtask

   task automatic test_random_traffic(int idle_pct, int stall_pct, int n_items);
      int                hot;
      int                roll;
      logic [CHAN_W-1:0] ch;
      cmd_type           op;
      src_idle_pct  = idle_pct;
      snk_stall_pct = stall_pct;
      hot = $urandom_range(NUM_CH - 1);
      for (int i = 0; i < n_items; i++) begin
         // bursts on one channel let fill levels climb
         if ($urandom_range(99) < 8) hot = $urandom_range(NUM_CH - 1);
         if ($urandom_range(99) < 4) ch = CHAN_W'($urandom_range(7, NUM_CH));
         else ch = CHAN_W'(hot);
         roll = $urandom_range(99);
         if (roll < 50)      op = CMD_PUSH;
         else if (roll < 84) op = CMD_POP;
         else if (roll < 89) op = CMD_FLUSH;
         else                op = CMD_QUERY;
         send_item(op, ch, BYTE_W'($urandom));
      end
      wait_drained();
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.cmd     = CMD_PUSH;
      req_ch.chan    = '0;
      req_ch.rx_byte = '0;
      rsp_ch.ready   = 1'b0;
      src_idle_pct   = 0;
      snk_stall_pct  = 0;
      hold_len       = 0;
      hold_left      = 0;
      fail_count     = 0;
      cycle_count    = 0;
      for (int c = 0; c < NUM_CH; c++) begin
         ring_wr[c]   = 0;
         ring_rd[c]   = 0;
         ring_fill[c] = 0;
      end
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_ops();
      test_full_overwrite();
      test_backpressure();
      test_random_traffic(0, 0, 120);
      test_random_traffic(84, 0, 120);
      test_random_traffic(0, 84, 120);
      test_random_traffic(18, 18, 120);

      repeat (8) @(posedge clock);
      if (pending_results.size() != 0) begin
         note_failure($sformatf("%0d results never arrived", pending_results.size()));
      end
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/mcrb_pkg.sv
rtl/mcrb_if.sv
rtl/multichannel_rx_ring_buffer_top.sv
rtl/mcrb_checker.sv
tb/tb.sv
